// ===== rtl/csf_pkg.sv =====
// ----------------------------------------------------------------------------
// csf_pkg: shared types and constants for chunk size fusion
// Payload structs, resolved register set, register indexes and the
// fallback values that stand in for zero registers.
// ----------------------------------------------------------------------------
package csf_pkg;

	localparam int unsigned FB_STEPS = 42;
	localparam int unsigned MD_STEPS = 40;
	localparam int unsigned FD_STEPS = 40;
	localparam int unsigned AL_STEPS = 40;
	localparam int unsigned Q_DEPTH  = 4;
	localparam int unsigned Q_PTR_W  = $clog2(Q_DEPTH);

	localparam logic [30:0] RST_MIN   = 31'd262144;
	localparam logic [30:0] RST_MAX   = 31'd5242880;
	localparam logic [30:0] RST_DEF   = 31'd2097152;
	localparam logic [30:0] RST_STEP  = 31'd524288;
	localparam logic [30:0] RST_ALIGN = 31'd16384;
	localparam logic [16:0] RST_ALPHA = 17'd19661;
	localparam logic [15:0] RST_TSEC  = 16'd768;
	localparam logic [39:0] RST_NORM  = 40'd10000000;
	localparam logic [41:0] RST_FB    = 42'd5592405;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	localparam logic [39:0] CAND_CAP   = 40'hFF_FFFF_FFFF;
	localparam logic [47:0] LOW_QUEUE  = 48'd1048576;
	localparam logic [47:0] HIGH_QUEUE = 48'd10485760;

	typedef enum logic [2:0] {
		REG_MIN_SIZE     = 3'd0,
		REG_MAX_SIZE     = 3'd1,
		REG_DEFAULT_SIZE = 3'd2,
		REG_STEP_SIZE    = 3'd3,
		REG_ALIGN_BYTES  = 3'd4,
		REG_EWMA_WEIGHT  = 3'd5,
		REG_TARGET_SEC   = 3'd6,
		REG_NORM_RATE    = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		TREND_GROW   = 2'd0,
		TREND_HOLD   = 2'd1,
		TREND_SHRINK = 2'd2
	} trend_t;

	typedef struct packed {
		logic [47:0] queue_bytes;
		logic [30:0] prev_size;
		logic [39:0] filter_rate;
		logic [39:0] model_rate;
		logic [1:0]  trend;
		logic        model_valid;
		logic [15:0] weight_base;
		logic [15:0] weight_queue;
		logic [15:0] weight_ewma;
		logic [15:0] weight_trend;
		logic [15:0] weight_model;
	} req_t;

	typedef struct packed {
		logic [30:0] base_out;
		logic [30:0] queue_out;
		logic [30:0] ewma_out;
		logic [30:0] trend_out;
		logic [30:0] model_out;
		logic [30:0] fused_out;
		logic [30:0] final_size;
	} rsp_t;

	// resolved register set: fallbacks applied, limits ordered
	typedef struct packed {
		logic [30:0] mn;
		logic [30:0] mx;
		logic [30:0] df;
		logic [30:0] st;
		logic [30:0] al;
		logic [16:0] alpha;
		logic [15:0] ts;
		logic [39:0] nr;
		logic [41:0] fb;
	} cfg_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [30:0]      prev;
		logic [30:0]      queue_cand;
		logic [30:0]      trend_cand;
		logic [44:0]      target;
		logic [41:0]      rate;
		logic             model_valid;
		logic [4:0][15:0] wt;
	} cls_t;

	function automatic logic [30:0] clamp40(input logic [39:0] v, input logic [30:0] lo,
		input logic [30:0] hi);
		logic [30:0] r;
		if (v < {9'b0, lo}) begin
			r = lo;
		end else if (v > {9'b0, hi}) begin
			r = hi;
		end else begin
			r = v[30:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/csf_cfg.sv =====
// ----------------------------------------------------------------------------
// csf_cfg: register file and resolved settings
// Holds the written registers, resolves fallbacks each cycle and recomputes
// the fallback rate with a serial divider after every write.
// ----------------------------------------------------------------------------
module csf_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [39:0]   cfg_data,
	output csf_pkg::cfg_t knobs,
	output logic          busy
);

	logic [30:0] min_q, max_q, def_q, step_q, align_q;
	logic [16:0] alpha_q;
	logic [15:0] tsec_q;
	logic [39:0] norm_q;

	logic [30:0] mn_c, mx0_c, mx_c, df0_c, df_c;
	csf_pkg::cfg_t knobs_q;

	logic [5:0]  cnt_q;
	logic [41:0] num_q;
	logic [15:0] rem_q;
	logic [16:0] fb_t;
	logic        fb_ge;
	logic [15:0] fb_rem_nx;
	logic [41:0] fb_num_nx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= csf_pkg::RST_MIN;
			max_q   <= csf_pkg::RST_MAX;
			def_q   <= csf_pkg::RST_DEF;
			step_q  <= csf_pkg::RST_STEP;
			align_q <= csf_pkg::RST_ALIGN;
			alpha_q <= csf_pkg::RST_ALPHA;
			tsec_q  <= csf_pkg::RST_TSEC;
			norm_q  <= csf_pkg::RST_NORM;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				csf_pkg::REG_MIN_SIZE:     min_q   <= cfg_data[30:0];
				csf_pkg::REG_MAX_SIZE:     max_q   <= cfg_data[30:0];
				csf_pkg::REG_DEFAULT_SIZE: def_q   <= cfg_data[30:0];
				csf_pkg::REG_STEP_SIZE:    step_q  <= cfg_data[30:0];
				csf_pkg::REG_ALIGN_BYTES:  align_q <= cfg_data[30:0];
				csf_pkg::REG_EWMA_WEIGHT:  alpha_q <= cfg_data[16:0];
				csf_pkg::REG_TARGET_SEC:   tsec_q  <= cfg_data[15:0];
				csf_pkg::REG_NORM_RATE:    norm_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		mn_c  = (min_q != 31'd0) ? min_q : csf_pkg::RST_MIN;
		mx0_c = (max_q != 31'd0) ? max_q : csf_pkg::RST_MAX;
		mx_c  = (mx0_c < mn_c) ? mn_c : mx0_c;
		df0_c = (def_q != 31'd0) ? def_q : csf_pkg::RST_DEF;
		if (df0_c < mn_c) begin
			df_c = mn_c;
		end else if (df0_c > mx_c) begin
			df_c = mx_c;
		end else begin
			df_c = df0_c;
		end
	end

	// one quotient bit of df * 2048 / ts per cycle
	always_comb begin
		fb_t      = {rem_q, num_q[41]};
		fb_ge     = (fb_t >= {1'b0, knobs_q.ts});
		fb_rem_nx = fb_ge ? 16'(fb_t - {1'b0, knobs_q.ts}) : fb_t[15:0];
		fb_num_nx = {num_q[40:0], fb_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (cfg_valid) begin
			cnt_q <= 6'(csf_pkg::FB_STEPS + 2);
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 6'(csf_pkg::FB_STEPS + 1)) begin
			num_q <= {knobs_q.df, 11'b0};
			rem_q <= 16'd0;
		end else if (cnt_q != 6'd0) begin
			num_q <= fb_num_nx;
			rem_q <= fb_rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knobs_q.mn    <= csf_pkg::RST_MIN;
			knobs_q.mx    <= csf_pkg::RST_MAX;
			knobs_q.df    <= csf_pkg::RST_DEF;
			knobs_q.st    <= csf_pkg::RST_STEP;
			knobs_q.al    <= csf_pkg::RST_ALIGN;
			knobs_q.alpha <= csf_pkg::RST_ALPHA;
			knobs_q.ts    <= csf_pkg::RST_TSEC;
			knobs_q.nr    <= csf_pkg::RST_NORM;
			knobs_q.fb    <= csf_pkg::RST_FB;
		end else begin
			knobs_q.mn    <= mn_c;
			knobs_q.mx    <= mx_c;
			knobs_q.df    <= df_c;
			knobs_q.st    <= (step_q != 31'd0) ? step_q : csf_pkg::RST_STEP;
			knobs_q.al    <= (align_q != 31'd0) ? align_q : csf_pkg::RST_ALIGN;
			knobs_q.alpha <= (alpha_q > csf_pkg::ALPHA_ONE) ? csf_pkg::ALPHA_ONE : alpha_q;
			knobs_q.ts    <= (tsec_q != 16'd0) ? tsec_q : csf_pkg::RST_TSEC;
			knobs_q.nr    <= (norm_q != 40'd0) ? norm_q : csf_pkg::RST_NORM;
			if (cnt_q == 6'd1 && !cfg_valid) begin
				knobs_q.fb <= fb_num_nx;
			end
		end
	end

	assign knobs = knobs_q;
	assign busy  = (cnt_q != 6'd0);

endmodule

// ===== rtl/csf_front.sv =====
// ----------------------------------------------------------------------------
// csf_front: request intake and classification
// Clamps the last size, forms the cheap candidates, the EWMA target and the
// model rate, and queues the classified item for the back end.
// ----------------------------------------------------------------------------
module csf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  csf_pkg::req_t req,
	input  csf_pkg::cfg_t knobs,
	input  logic          cfg_busy,
	input  logic          cfg_valid,
	input  logic          pop,
	output logic          head_valid,
	output csf_pkg::cls_t head
);

	csf_pkg::cls_t cls_c;
	logic [30:0]   prev_c;
	logic [31:0]   up_c, lo_lim_c;
	logic [55:0]   tgt_prod_c;

	csf_pkg::cls_t mem_q [csf_pkg::Q_DEPTH];
	logic [csf_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [csf_pkg::Q_PTR_W:0]   count_q;
	logic push;

	always_comb begin
		prev_c     = csf_pkg::clamp40({9'b0, req.prev_size}, knobs.mn, knobs.mx);
		up_c       = {1'b0, prev_c} + {1'b0, knobs.st};
		lo_lim_c   = {1'b0, knobs.mn} + {1'b0, knobs.st};
		tgt_prod_c = 56'(req.filter_rate) * 56'(knobs.ts);

		cls_c      = '0;
		cls_c.prev = prev_c;

		if (req.queue_bytes < csf_pkg::LOW_QUEUE) begin
			cls_c.queue_cand = knobs.mx;
		end else if (req.queue_bytes < csf_pkg::HIGH_QUEUE) begin
			cls_c.queue_cand = knobs.df;
		end else begin
			cls_c.queue_cand = knobs.mn;
		end

		case (req.trend)
			csf_pkg::TREND_GROW:
				cls_c.trend_cand = (up_c > {1'b0, knobs.mx}) ? knobs.mx : up_c[30:0];
			csf_pkg::TREND_SHRINK:
				cls_c.trend_cand = ({1'b0, prev_c} >= lo_lim_c) ? 31'(prev_c - knobs.st)
					: knobs.mn;
			default:
				cls_c.trend_cand = prev_c;
		endcase

		// bytes moved in the target time; Q8.8 seconds over 8 bits per byte
		cls_c.target = (req.filter_rate != 40'd0) ? tgt_prod_c[55:11] : {14'b0, knobs.df};

		if (req.model_rate != 40'd0) begin
			cls_c.rate = {2'b0, req.model_rate};
		end else if (req.filter_rate != 40'd0) begin
			cls_c.rate = {2'b0, req.filter_rate};
		end else begin
			cls_c.rate = knobs.fb;
		end

		cls_c.model_valid = req.model_valid;
		cls_c.wt[0]       = req.weight_base;
		cls_c.wt[1]       = req.weight_queue;
		cls_c.wt[2]       = req.weight_ewma;
		cls_c.wt[3]       = req.weight_trend;
		cls_c.wt[4]       = req.weight_model;
	end

	// hold off while the queue is full or settings are changing
	assign req_ready  = (count_q != (csf_pkg::Q_PTR_W + 1)'(csf_pkg::Q_DEPTH)) && !cfg_busy
		&& !cfg_valid;
	assign push       = req_valid && req_ready;
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/csf_back.sv =====
// ----------------------------------------------------------------------------
// csf_back: candidate arithmetic, fusion and alignment pipeline
// Multiplies, divides bit by bit per stage, ranks the candidates, forms the
// weighted trimmed mean and aligns it; the last stage is the output register.
// ----------------------------------------------------------------------------
module csf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  csf_pkg::cfg_t knobs,
	input  logic          head_valid,
	input  csf_pkg::cls_t head,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output csf_pkg::rsp_t rsp
);

	localparam int unsigned MD = csf_pkg::MD_STEPS;
	localparam int unsigned FD = csf_pkg::FD_STEPS;
	localparam int unsigned AL = csf_pkg::AL_STEPS;

	typedef struct packed {
		logic [30:0]      queue_cand;
		logic [30:0]      trend_cand;
		logic             model_valid;
		logic [4:0][15:0] wt;
	} side_t;

	typedef struct packed {
		logic [39:0] rem;
		logic [39:0] low;
		logic [39:0] quo;
		logic        sat;
		side_t       side;
		logic [39:0] ewma_cand;
		logic [30:0] ewma_out;
	} md_t;

	typedef struct packed {
		logic [17:0] rem;
		logic [39:0] low;
		logic [39:0] quo;
		logic [17:0] tot;
		csf_pkg::rsp_t r;
	} fd_t;

	typedef struct packed {
		logic [30:0] rem;
		logic [39:0] low;
		logic [39:0] fused;
		csf_pkg::rsp_t r;
	} al_t;

	function automatic md_t md_step(input md_t x, input logic [39:0] d);
		logic [40:0] t;
		logic        ge;
		md_t         y;
		y     = x;
		t     = {x.rem, x.low[39]};
		ge    = (t >= {1'b0, d});
		y.rem = ge ? 40'(t - {1'b0, d}) : t[39:0];
		y.low = {x.low[38:0], 1'b0};
		y.quo = {x.quo[38:0], ge};
		return y;
	endfunction

	function automatic fd_t fd_step(input fd_t x);
		logic [18:0] t;
		logic        ge;
		fd_t         y;
		y     = x;
		t     = {x.rem, x.low[39]};
		ge    = (t >= {1'b0, x.tot});
		y.rem = ge ? 18'(t - {1'b0, x.tot}) : t[17:0];
		y.low = {x.low[38:0], 1'b0};
		y.quo = {x.quo[38:0], ge};
		return y;
	endfunction

	function automatic al_t al_step(input al_t x, input logic [30:0] d);
		logic [31:0] t;
		logic        ge;
		al_t         y;
		y     = x;
		t     = {x.rem, x.low[39]};
		ge    = (t >= {1'b0, d});
		y.rem = ge ? 31'(t - {1'b0, d}) : t[30:0];
		y.low = {x.low[38:0], 1'b0};
		return y;
	endfunction

	logic adv;

	// products stage
	logic        v_s1;
	logic [52:0] pm_lo_s1;
	logic [50:0] pm_hi_s1;
	logic [47:0] ea_s1;
	logic [39:0] etl_s1;
	logic [38:0] eth_s1;
	side_t       side_s1;
	logic [16:0] inv_alpha;

	// sums stage
	logic        v_s2;
	logic [72:0] n_s2;
	side_t       side_s2;
	logic [39:0] ewma_cand_s2;
	logic [30:0] ewma_out_s2;
	logic [62:0] e_sum;
	logic [46:0] e_val;
	logic [39:0] ewma_sat;

	// model division
	logic [MD-1:0] md_v_s;
	md_t           md_s [MD];
	md_t           md_init;

	// fusion stages
	logic [4:0][39:0] cand_c;
	logic [4:0]       act_c, mid_c;
	logic [2:0]       rank_c [5];
	logic [2:0]       last_c;
	logic [39:0]      model_cand;

	logic             fu_v_s1, fu_v_s2, fu_v_s3, fu_v_s4;
	logic [4:0][39:0] fu_cand_s1;
	logic [4:0][15:0] fu_wt_s1;
	csf_pkg::rsp_t    fu_rsp_s1, fu_rsp_s2, fu_rsp_s3, fu_rsp_s4;
	logic [4:0][55:0] fu_prod_s2;
	logic [17:0]      fu_tot_s2, fu_tot_s3, fu_tot_s4;
	logic [57:0]      fu_sa_s3, fu_sb_s3;
	logic [57:0]      fu_sum_s4;

	// fused division and alignment
	logic [FD-1:0] fd_v_s;
	fd_t           fd_s [FD];
	fd_t           fd_init;
	logic [39:0]   fused_c;

	logic [AL-1:0] al_v_s;
	al_t           al_s [AL];
	al_t           al_init;
	logic [39:0]   fin_c;

	logic          rsp_v_q;
	csf_pkg::rsp_t rsp_q;
	csf_pkg::rsp_t rsp_c;

	// advance the whole pipe unless a finished beat waits at the output
	assign adv = !rsp_v_q || rsp_ready;
	assign pop = adv && head_valid;

	assign inv_alpha = 17'(csf_pkg::ALPHA_ONE - knobs.alpha);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			md_v_s  <= '0;
			fu_v_s1 <= 1'b0;
			fu_v_s2 <= 1'b0;
			fu_v_s3 <= 1'b0;
			fu_v_s4 <= 1'b0;
			fd_v_s  <= '0;
			al_v_s  <= '0;
			rsp_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= head_valid;
			v_s2    <= v_s1;
			md_v_s  <= {md_v_s[MD-2:0], v_s2};
			fu_v_s1 <= md_v_s[MD-1];
			fu_v_s2 <= fu_v_s1;
			fu_v_s3 <= fu_v_s2;
			fu_v_s4 <= fu_v_s3;
			fd_v_s  <= {fd_v_s[FD-2:0], fu_v_s4};
			al_v_s  <= {al_v_s[AL-2:0], fd_v_s[FD-1]};
			rsp_v_q <= al_v_s[AL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pm_lo_s1           <= 53'(knobs.df) * 53'(head.rate[21:0]);
			pm_hi_s1           <= 51'(knobs.df) * 51'(head.rate[41:22]);
			ea_s1              <= 48'(head.prev) * 48'(inv_alpha);
			etl_s1             <= 40'(head.target[22:0]) * 40'(knobs.alpha);
			eth_s1             <= 39'(head.target[44:23]) * 39'(knobs.alpha);
			side_s1.queue_cand  <= head.queue_cand;
			side_s1.trend_cand  <= head.trend_cand;
			side_s1.model_valid <= head.model_valid;
			side_s1.wt          <= head.wt;
		end
	end

	always_comb begin
		e_sum    = 63'(ea_s1) + 63'(etl_s1) + 63'({eth_s1, 23'b0});
		e_val    = e_sum[62:16];
		ewma_sat = (e_val[46:40] != 7'd0) ? csf_pkg::CAND_CAP : e_val[39:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s2         <= 73'(pm_lo_s1) + {pm_hi_s1, 22'b0};
			side_s2      <= side_s1;
			ewma_cand_s2 <= ewma_sat;
			ewma_out_s2  <= csf_pkg::clamp40(ewma_sat, knobs.mn, knobs.mx);
		end
	end

	// model quotient: saturate when the top part already reaches the divisor
	always_comb begin
		md_init           = '0;
		md_init.rem       = {7'b0, n_s2[72:40]};
		md_init.low       = n_s2[39:0];
		md_init.sat       = ({7'b0, n_s2[72:40]} >= knobs.nr);
		md_init.side      = side_s2;
		md_init.ewma_cand = ewma_cand_s2;
		md_init.ewma_out  = ewma_out_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			md_s[0] <= md_step(md_init, knobs.nr);
			for (int k = 1; k < MD; k++) begin
				md_s[k] <= md_step(md_s[k-1], knobs.nr);
			end
		end
	end

	// rank with ties broken by input order, keep all but the extremes
	always_comb begin
		model_cand = md_s[MD-1].sat ? csf_pkg::CAND_CAP : md_s[MD-1].quo;
		cand_c[0]  = {9'b0, knobs.df};
		cand_c[1]  = {9'b0, md_s[MD-1].side.queue_cand};
		cand_c[2]  = md_s[MD-1].ewma_cand;
		cand_c[3]  = {9'b0, md_s[MD-1].side.trend_cand};
		cand_c[4]  = model_cand;
		act_c      = {md_s[MD-1].side.model_valid, 4'b1111};
		last_c     = md_s[MD-1].side.model_valid ? 3'd3 : 3'd2;
		for (int i = 0; i < 5; i++) begin
			rank_c[i] = 3'd0;
			for (int j = 0; j < 5; j++) begin
				if (j != i && act_c[j] && ((cand_c[j] < cand_c[i]) ||
					(cand_c[j] == cand_c[i] && j < i))) begin
					rank_c[i] = rank_c[i] + 3'd1;
				end
			end
			mid_c[i] = act_c[i] && (rank_c[i] >= 3'd1) && (rank_c[i] <= last_c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fu_cand_s1 <= cand_c;
			for (int i = 0; i < 5; i++) begin
				fu_wt_s1[i] <= mid_c[i] ? md_s[MD-1].side.wt[i] : 16'd0;
			end
			fu_rsp_s1.base_out   <= knobs.df;
			fu_rsp_s1.queue_out  <= md_s[MD-1].side.queue_cand;
			fu_rsp_s1.ewma_out   <= md_s[MD-1].ewma_out;
			fu_rsp_s1.trend_out  <= md_s[MD-1].side.trend_cand;
			fu_rsp_s1.model_out  <= csf_pkg::clamp40(model_cand, knobs.mn, knobs.mx);
			fu_rsp_s1.fused_out  <= 31'd0;
			fu_rsp_s1.final_size <= 31'd0;

			for (int i = 0; i < 5; i++) begin
				fu_prod_s2[i] <= 56'(fu_cand_s1[i]) * 56'(fu_wt_s1[i]);
			end
			fu_tot_s2 <= 18'(fu_wt_s1[0]) + 18'(fu_wt_s1[1]) + 18'(fu_wt_s1[2])
				+ 18'(fu_wt_s1[3]) + 18'(fu_wt_s1[4]);
			fu_rsp_s2 <= fu_rsp_s1;

			fu_sa_s3  <= 58'(fu_prod_s2[0]) + 58'(fu_prod_s2[1]) + 58'(fu_prod_s2[2]);
			fu_sb_s3  <= 58'(fu_prod_s2[3]) + 58'(fu_prod_s2[4]);
			fu_tot_s3 <= fu_tot_s2;
			fu_rsp_s3 <= fu_rsp_s2;

			fu_sum_s4 <= fu_sa_s3 + fu_sb_s3;
			fu_tot_s4 <= fu_tot_s3;
			fu_rsp_s4 <= fu_rsp_s3;
		end
	end

	always_comb begin
		fd_init     = '0;
		fd_init.rem = fu_sum_s4[57:40];
		fd_init.low = fu_sum_s4[39:0];
		fd_init.tot = fu_tot_s4;
		fd_init.r   = fu_rsp_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fd_s[0] <= fd_step(fd_init);
			for (int k = 1; k < FD; k++) begin
				fd_s[k] <= fd_step(fd_s[k-1]);
			end
		end
	end

	// no positive weight in the middle: fall back to the default size
	always_comb begin
		fused_c                = (fd_s[FD-1].tot == 18'd0) ? {9'b0, knobs.df} : fd_s[FD-1].quo;
		al_init                = '0;
		al_init.low            = fused_c;
		al_init.fused          = fused_c;
		al_init.r              = fd_s[FD-1].r;
		al_init.r.fused_out    = csf_pkg::clamp40(fused_c, knobs.mn, knobs.mx);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			al_s[0] <= al_step(al_init, knobs.al);
			for (int k = 1; k < AL; k++) begin
				al_s[k] <= al_step(al_s[k-1], knobs.al);
			end
		end
	end

	assign fin_c = al_s[AL-1].fused - {9'b0, al_s[AL-1].rem};

	always_comb begin
		rsp_c            = al_s[AL-1].r;
		rsp_c.final_size = csf_pkg::clamp40(fin_c, knobs.mn, knobs.mx);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/chunk_size_fusion.sv =====
// ----------------------------------------------------------------------------
// chunk_size_fusion: upload chunk size decision
// Fuses default, queue, EWMA, trend and model candidates into one size.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock while ready and returns one
// response beat per request, in order. Each request passes a short front
// end that clamps the last size and forms the cheap candidates, a four-entry
// queue, and a back-end pipeline of 127 stages: two for the products, forty
// for the model quotient (one bit per stage), four for ranking and the
// weighted sums, forty for the weighted mean and forty for the alignment
// remainder, then the output register. Throughput is one beat per cycle
// while responses are taken. A held response stalls the whole back end
// while the queue keeps taking requests until it is full. A write on the
// settings port recomputes the fallback rate (default * 2048 / target
// seconds) on a serial divider, one bit per cycle: requests are refused
// from a write until the divider is done. Settings writes are always taken.
// ----------------------------------------------------------------------------
module chunk_size_fusion (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  csf_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output csf_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [39:0]   cfg_data
);

	csf_pkg::cfg_t knobs;
	csf_pkg::cls_t head;
	logic          cfg_busy;
	logic          head_valid;
	logic          pop;

	// registers, fallbacks and the fallback-rate divider
	csf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.knobs     (knobs),
		.busy      (cfg_busy)
	);

	// accept and classify each beat, then queue it
	csf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.knobs      (knobs),
		.cfg_busy   (cfg_busy),
		.cfg_valid  (cfg_valid),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// drain the queue through the arithmetic pipeline
	csf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.knobs      (knobs),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule
